### rtl/core/bqpk_pkg.sv
// ----------------------------------------------------------------------------
// bqpk_pkg
// Shared widths, coefficient reset values and codes for the peaking biquad.
// ----------------------------------------------------------------------------
`default_nettype none

package bqpk_pkg;

    // sample and coefficient formats
    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 24;
    localparam int NORM_W    = 29;
    localparam int NORM_FRAC = 30;

    // five products of COEF_W x SAMPLE_W plus growth for the sum
    localparam int ACC_W  = COEF_W + SAMPLE_W + 2;
    localparam int MAG_W  = ACC_W - 1;
    localparam int HI_W   = MAG_W - NORM_FRAC;
    localparam int SCL_W  = MAG_W;
    localparam int RMAG_W = SCL_W - COEF_FRAC;

    // shared multiplier operands are signed, one bit above the coefficient
    localparam int OP_W   = COEF_W + 1;
    localparam int PROD_W = 2 * OP_W;

    localparam logic [SCL_W-1:0]  RND_HALF = SCL_W'(1) << (COEF_FRAC - 1);
    localparam logic [RMAG_W-1:0] POS_LIM  = (RMAG_W'(1) << (SAMPLE_W - 1)) - RMAG_W'(1);
    localparam logic [RMAG_W-1:0] NEG_LIM  = RMAG_W'(1) << (SAMPLE_W - 1);

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_FWD0 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FWD1 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FWD2 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FBK1 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FBK2 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_NORM = 3'd5;

    // coefficient reset values, identity response
    localparam logic [COEF_W-1:0] RST_FWD0 = 32'h0400_0000;
    localparam logic [COEF_W-1:0] RST_FWD1 = 32'hF800_0000;
    localparam logic [COEF_W-1:0] RST_FWD2 = 32'h0400_0000;
    localparam logic [COEF_W-1:0] RST_FBK1 = 32'h0800_0000;
    localparam logic [COEF_W-1:0] RST_FBK2 = 32'hFC00_0000;
    localparam logic [NORM_W-1:0] RST_NORM = 29'h1000_0000;

    // multiplier operand select codes
    localparam int SEL_W = 3;
    localparam logic [SEL_W-1:0] SEL_FWD0 = 3'd0;
    localparam logic [SEL_W-1:0] SEL_FWD1 = 3'd1;
    localparam logic [SEL_W-1:0] SEL_FWD2 = 3'd2;
    localparam logic [SEL_W-1:0] SEL_FBK1 = 3'd3;
    localparam logic [SEL_W-1:0] SEL_FBK2 = 3'd4;
    localparam logic [SEL_W-1:0] SEL_NHI  = 3'd5;
    localparam logic [SEL_W-1:0] SEL_NLO  = 3'd6;

    // controller to datapath commands
    typedef struct packed {
        logic             load;       // capture new sample, clear accumulator
        logic             mul_en;     // register one product
        logic [SEL_W-1:0] mul_sel;
        logic             acc_add;    // add registered product to accumulator
        logic             mag_en;     // split accumulator into sign and magnitude
        logic             scale_hi;   // take upper normalizer product
        logic             scale_sum;  // add lower product and rounding half
        logic             commit;     // saturate, update delays, load output
    } t_dp_cmd;

endpackage

`default_nettype wire

### rtl/core/bqpk_ctrl.sv
// ----------------------------------------------------------------------------
// bqpk_ctrl
// Sequencer for the biquad: steps the shared multiplier and owns the
// handshake state of both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module bqpk_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output bqpk_pkg::t_dp_cmd     o_cmd
);
    import bqpk_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_MAG  = 3'd3;
    localparam logic [2:0] ST_NHI  = 3'd4;
    localparam logic [2:0] ST_NLO  = 3'd5;
    localparam logic [2:0] ST_NSUM = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    localparam logic [SEL_W-1:0] LAST_TAP = SEL_FBK2;

    logic [2:0]       r_state, n_state;
    logic [SEL_W-1:0] r_step, n_step;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                n_step = SEL_FWD0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = r_step;
                o_cmd.acc_add = (r_step != SEL_FWD0);
                n_step        = r_step + SEL_W'(1);
                if (r_step == LAST_TAP) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state       = ST_MAG;
            end
            ST_MAG: begin
                o_cmd.mag_en = 1'b1;
                n_state      = ST_NHI;
            end
            ST_NHI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = SEL_NHI;
                n_state       = ST_NLO;
            end
            ST_NLO: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = SEL_NLO;
                o_cmd.scale_hi = 1'b1;
                n_state        = ST_NSUM;
            end
            ST_NSUM: begin
                o_cmd.scale_sum = 1'b1;
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                // wait until the output register can take the result
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= SEL_FWD0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### rtl/core/bqpk_dp.sv
// ----------------------------------------------------------------------------
// bqpk_dp
// Biquad datapath: coefficient registers, delay line, one shared signed
// multiplier, accumulator, normalizer scaling, rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module bqpk_dp (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  bqpk_pkg::t_dp_cmd                         i_cmd,
    input  wire signed [bqpk_pkg::SAMPLE_W-1:0]       i_sample,
    input  wire                                       i_cfg_we,
    input  wire        [bqpk_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire        [bqpk_pkg::COEF_W-1:0]         i_cfg_data,
    output logic signed [bqpk_pkg::SAMPLE_W-1:0]      o_sample,
    output logic                                      o_clipped
);
    import bqpk_pkg::*;

    // coefficients
    logic signed [COEF_W-1:0] r_fwd0, r_fwd1, r_fwd2, r_fbk1, r_fbk2;
    logic        [NORM_W-1:0] r_norm;

    // delay line and current sample
    logic signed [SAMPLE_W-1:0] r_x0, r_x1, r_x2, r_y1, r_y2;

    // arithmetic registers
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_neg;
    logic        [MAG_W-1:0]  r_mag;
    logic        [SCL_W-1:0]  r_scaled;
    logic signed [SAMPLE_W-1:0] r_sample_out;
    logic                       r_clipped;

    logic signed [OP_W-1:0]     w_op_a, w_op_b;
    logic signed [COEF_W-1:0]   w_tap;
    logic signed [SAMPLE_W-1:0] w_smp;
    logic signed [ACC_W-1:0]    w_acc_neg;
    logic        [RMAG_W-1:0]   w_rmag, w_rmag_sat;
    logic                       w_clip;
    logic signed [SAMPLE_W-1:0] w_y;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd0 <= RST_FWD0;
            r_fwd1 <= RST_FWD1;
            r_fwd2 <= RST_FWD2;
            r_fbk1 <= RST_FBK1;
            r_fbk2 <= RST_FBK2;
            r_norm <= RST_NORM;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FWD0: r_fwd0 <= i_cfg_data;
                REG_FWD1: r_fwd1 <= i_cfg_data;
                REG_FWD2: r_fwd2 <= i_cfg_data;
                REG_FBK1: r_fbk1 <= i_cfg_data;
                REG_FBK2: r_fbk2 <= i_cfg_data;
                REG_NORM: r_norm <= i_cfg_data[NORM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // multiplier operand select
    always_comb begin
        w_tap = r_fwd0;
        w_smp = r_x0;
        case (i_cmd.mul_sel)
            SEL_FWD0: begin w_tap = r_fwd0; w_smp = r_x0; end
            SEL_FWD1: begin w_tap = r_fwd1; w_smp = r_x1; end
            SEL_FWD2: begin w_tap = r_fwd2; w_smp = r_x2; end
            SEL_FBK1: begin w_tap = r_fbk1; w_smp = r_y1; end
            SEL_FBK2: begin w_tap = r_fbk2; w_smp = r_y2; end
            default: begin
            end
        endcase

        w_op_a = {w_tap[COEF_W-1], w_tap};
        w_op_b = {{(OP_W-SAMPLE_W){w_smp[SAMPLE_W-1]}}, w_smp};
        case (i_cmd.mul_sel)
            SEL_NHI: begin
                w_op_a = {{(OP_W-HI_W){1'b0}}, r_mag[MAG_W-1:NORM_FRAC]};
                w_op_b = {{(OP_W-NORM_W){1'b0}}, r_norm};
            end
            SEL_NLO: begin
                w_op_a = {{(OP_W-NORM_FRAC){1'b0}}, r_mag[NORM_FRAC-1:0]};
                w_op_b = {{(OP_W-NORM_W){1'b0}}, r_norm};
            end
            default: begin
            end
        endcase
    end

    assign w_acc_neg = -r_acc;

    // round, then clamp to the sample range
    always_comb begin
        w_rmag     = r_scaled[SCL_W-1:COEF_FRAC];
        w_clip     = r_neg ? (w_rmag > NEG_LIM) : (w_rmag > POS_LIM);
        w_rmag_sat = w_clip ? (r_neg ? NEG_LIM : POS_LIM) : w_rmag;
        w_y        = r_neg ? -w_rmag_sat[SAMPLE_W-1:0] : w_rmag_sat[SAMPLE_W-1:0];
    end

    // shared multiplier, accumulator and scaling
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0  <= i_sample;
            r_acc <= '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_op_a * w_op_b;
        end
        if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod[ACC_W-1:0];
        end
        if (i_cmd.mag_en) begin
            r_neg <= r_acc[ACC_W-1];
            r_mag <= r_acc[ACC_W-1] ? w_acc_neg[MAG_W-1:0] : r_acc[MAG_W-1:0];
        end
        if (i_cmd.scale_hi) begin
            r_scaled <= r_prod[SCL_W-1:0];
        end
        if (i_cmd.scale_sum) begin
            r_scaled <= r_scaled + RND_HALF
                      + {{(SCL_W-NORM_W){1'b0}}, r_prod[NORM_FRAC+NORM_W-1:NORM_FRAC]};
        end
        if (i_cmd.commit) begin
            r_sample_out <= w_y;
            r_clipped    <= w_clip;
        end
    end

    // delay line, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_cmd.commit) begin
            r_x1 <= r_x0;
            r_x2 <= r_x1;
            r_y1 <= w_y;
            r_y2 <= r_y1;
        end
    end

    assign o_sample  = r_sample_out;
    assign o_clipped = r_clipped;

endmodule

`default_nettype wire

### rtl/core/biquad_peaking_filter_core.sv
// From an input transfer, tap, accumulate, magnitude, normalizer and rounding steps
//   run before m_axis_tvalid, plus any output stall. The next sample waits for commit,
//   as five tap and two normalizer products share the one 33x33 multiplier.
// A finished sample waits in the output register while the next one is taken.
// Reset (i_rst_n low, synchronous) clears the delay line and loads the
//   identity coefficients.
// ----------------------------------------------------------------------------
// biquad_peaking_filter_core
// Direct form 1 peaking EQ biquad on signed 24-bit samples, with
// rounding, saturation and a clip flag per output sample.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_peaking_filter_core (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // input stream
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire  [bqpk_pkg::SAMPLE_W-1:0]         s_axis_tdata,   // [23:0] sample_in
    // output stream
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    output logic [bqpk_pkg::SAMPLE_W-1:0]         m_axis_tdata,   // [23:0] sample_out
    output logic                                  m_axis_tuser,   // [0] clipped
    // configuration write channel
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [bqpk_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire  [bqpk_pkg::COEF_W-1:0]           i_cfg_data
);
    import bqpk_pkg::*;

    t_dp_cmd                    w_cmd;
    logic signed [SAMPLE_W-1:0] w_sample_out;

    assign o_cfg_ready = 1'b1;

    // sequencer
    bqpk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    // arithmetic
    bqpk_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_sample   (s_axis_tdata),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_sample   (w_sample_out),
        .o_clipped  (m_axis_tuser)
    );

    assign m_axis_tdata = w_sample_out;

endmodule

`default_nettype wire

### rtl/core/bqpk_checker.sv
// ----------------------------------------------------------------------------
// bqpk_checker
// Port-level checks on the biquad core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bqpk_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                s_axis_tvalid,
    input wire                                s_axis_tready,
    input wire                                m_axis_tvalid,
    input wire                                m_axis_tready,
    input wire [bqpk_pkg::SAMPLE_W-1:0]       m_axis_tdata,
    input wire                                m_axis_tuser
);
    import bqpk_pkg::*;

    localparam logic [SAMPLE_W-1:0] MAX_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] MAX_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // one sample in work at a time: input closes after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // clipped samples sit at a range limit
    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == MAX_POS || m_axis_tdata == MAX_NEG)
        else $error("clip flag without a limit value");

    // stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

endmodule

bind biquad_peaking_filter_core bqpk_checker u_bqpk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
